// ----- rtl/core/assert_macros.svh -----
// concurrent assertion helpers, empty for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PIDC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pidc assertion failed");
`define PIDC_ASSERT_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define PIDC_ASSERT(label, clk, rst, prop)
`define PIDC_ASSERT_MSG(label, clk, rst, prop, msg)
`endif

`endif

// ----- rtl/core/pidc_pkg.sv -----
package pidc_pkg;

   localparam int NARROW_W         = 32;
   localparam int TERM_W           = 50;
   localparam int VAL_W            = TERM_W + 2;
   localparam int DATA_W           = 32;
   localparam int STEP_W           = 31;
   localparam int EXCESS_W         = 33;
   localparam int FRAC_W           = 17;
   localparam int CSR_IDX_W        = 3;
   localparam int REQ_DATA_W       = 96;
   localparam int RESET_FRAC_SHIFT = 16;

   localparam logic [TERM_W-1:0]   TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};
   localparam logic [TERM_W-1:0]   TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
   localparam logic [EXCESS_W-1:0] EXC_MIN  = {1'b1, {(EXCESS_W-1){1'b0}}};
   localparam logic [EXCESS_W-1:0] EXC_MAX  = {1'b0, {(EXCESS_W-1){1'b1}}};
   localparam logic [DATA_W-1:0]   LOWER_RESET = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0]   UPPER_RESET = {1'b0, {(DATA_W-1){1'b1}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_OUT_LOWER  = 3'd3,
      CSR_OUT_UPPER  = 3'd4,
      CSR_SIGN_RESET = 3'd5,
      CSR_RESET_FRAC = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_RUN,
      S_POST,
      S_APPLY,
      S_CLAMP,
      S_EXCESS,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_INT,
      OP_DIV,
      OP_P,
      OP_I,
      OP_D
   } op_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ----- rtl/core/pid_controller_antiwindup_core.sv -----
// pid regulator, signed q16.16, back-calculation anti-windup
// req channel: one word per step; tuser low = update, high = preset
//    an update integrates, differentiates and sums the three gain terms,
//    a preset loads the output and clears error, integral and excess
// rsp channel: exactly one word per request word, in order
// csr channel: register writes by index, always ready; the user writes
//    registers only while idle, the block itself does not enforce it
// one item at a time; the shared shift-add multiply / restoring divide
//    unit runs four 32-step products and one 33 + FRAC_BITS step divide
// the result sits in an output register, so a new word is taken while
//    the previous result waits; a second result waits until it drains
// reset clears integral, excess, last error and sign (positive) and
//    loads the register reset values
`include "assert_macros.svh"

module pid_controller_antiwindup_core
   import pidc_pkg::*;
#(
   parameter int FRAC_BITS      = 16,
   parameter int INTEGRAL_WIDTH = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // error_in [31:0], time_step [62:32], preset_value [94:63]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // control_out [31:0]
   output logic [DATA_W-1:0]     rsp_tdata,
   // limited
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]     csr_data
);

   localparam int NUM_W  = DATA_W + 1 + FRAC_BITS;
   localparam int MAG_W  = (INTEGRAL_WIDTH > NUM_W) ? INTEGRAL_WIDTH : NUM_W;
   localparam int SRC_W  = MAG_W + 1;
   localparam int DER_W  = NUM_W + 1;
   localparam int PROD_W = MAG_W + NARROW_W;
   localparam int EXT_W  = ((INTEGRAL_WIDTH > TERM_W) ? INTEGRAL_WIDTH : TERM_W) + 2;
   localparam int LO_W_FIX = NUM_W;
   localparam logic [INTEGRAL_WIDTH-1:0] INT_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
   localparam logic [INTEGRAL_WIDTH-1:0] INT_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};

   // configuration
   logic signed [DATA_W-1:0] gain_p_ff, gain_p_in;
   logic signed [DATA_W-1:0] gain_i_ff, gain_i_in;
   logic signed [DATA_W-1:0] gain_d_ff, gain_d_in;
   logic signed [DATA_W-1:0] lower_ff, lower_in;
   logic signed [DATA_W-1:0] upper_ff, upper_in;
   logic                     sre_ff, sre_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;

   // control and regulator state
   state_type                        state_ff, state_in;
   op_type                           op_ff, op_in;
   logic signed [DATA_W-1:0]         last_ff, last_in;
   logic signed [INTEGRAL_WIDTH-1:0] integral_ff, integral_in;
   logic                             sign_ff, sign_in;
   logic signed [EXCESS_W-1:0]       excess_ff, excess_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // working registers
   logic signed [DATA_W-1:0] err_ff, err_in;
   logic [STEP_W-1:0]        dt_ff, dt_in;
   logic signed [DER_W-1:0]  deriv_ff, deriv_in;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic signed [VAL_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0] clamped_ff, clamped_in;
   logic                     limited_ff, limited_in;
   logic                     reduce_ff, reduce_in;
   logic                     neg_ff, neg_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;

   // shared unit
   unit_ctrl_type    unit_ctrl;
   unit_status_type  unit_status;
   logic [MAG_W-1:0] unit_a;
   logic [LO_W_FIX-1:0] unit_b;
   logic [MAG_W-1:0] unit_hi;
   logic [NUM_W-1:0] unit_lo;

   // datapath
   logic signed [DATA_W+1:0]         diff_ex;
   logic signed [DATA_W:0]           diff_last;
   logic signed [SRC_W-1:0]          src;
   logic [SRC_W-1:0]                 src_abs;
   logic [MAG_W-1:0]                 src_mag;
   logic signed [DATA_W-1:0]         gain_sel;
   logic [NARROW_W-1:0]              gain_abs;
   logic [NARROW_W-1:0]              narrow_mag;
   logic [PROD_W-1:0]                prod;
   logic [PROD_W-1:0]                quo;
   logic                             rem;
   logic                             use16;
   logic                             ovf;
   logic [TERM_W-1:0]                mag_t;
   logic [TERM_W-1:0]                term_post;
   logic [DER_W-1:0]                 q_ext;
   logic [DER_W-1:0]                 deriv_post;
   logic signed [EXT_W-1:0]          ext_int;
   logic signed [EXT_W-1:0]          ext_term;
   logic signed [EXT_W-1:0]          isum;
   logic [INTEGRAL_WIDTH-1:0]        int_sat;
   logic signed [VAL_W-1:0]          upper_ext;
   logic signed [VAL_W-1:0]          lower_ext;
   logic signed [VAL_W-1:0]          clamp_hi;
   logic signed [VAL_W-1:0]          clamp_lo;
   logic signed [VAL_W-1:0]          xdiff;
   logic                             x_ok;
   logic [EXCESS_W-1:0]              excess_sat;

   pidc_iter_unit #(
      .MAG_W (MAG_W),
      .LO_W  (LO_W_FIX)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (unit_ctrl),
      .op_a   (unit_a),
      .op_b   (unit_b),
      .status (unit_status),
      .hi     (unit_hi),
      .lo     (unit_lo)
   );

   // operand selection for the shared unit
   always_comb begin
      diff_ex   = {{2{err_ff[DATA_W-1]}}, err_ff} - {excess_ff[EXCESS_W-1], excess_ff};
      diff_last = {err_ff[DATA_W-1], err_ff} - {last_ff[DATA_W-1], last_ff};

      case (op_ff)
         OP_INT:  src = reduce_ff ? SRC_W'(integral_ff) : SRC_W'(diff_ex);
         OP_DIV:  src = SRC_W'(diff_last);
         OP_P:    src = SRC_W'(err_ff);
         OP_I:    src = SRC_W'(integral_ff);
         OP_D:    src = SRC_W'(deriv_ff);
         default: src = '0;
      endcase
      src_abs = src[SRC_W-1] ? -src : src;
      src_mag = src_abs[MAG_W-1:0];

      case (op_ff)
         OP_P:    gain_sel = gain_p_ff;
         OP_I:    gain_sel = gain_i_ff;
         OP_D:    gain_sel = gain_d_ff;
         default: gain_sel = '0;
      endcase
      gain_abs = gain_sel[DATA_W-1] ? -gain_sel : gain_sel;

      if (op_ff == OP_INT) begin
         narrow_mag = reduce_ff ? NARROW_W'(frac_ff) : NARROW_W'(dt_ff);
      end else begin
         narrow_mag = gain_abs;
      end

      unit_ctrl.start  = (state_ff == S_LOAD);
      unit_ctrl.is_div = (op_ff == OP_DIV);
      if (op_ff == OP_DIV) begin
         unit_a = MAG_W'(dt_ff);
         unit_b = {src_mag[DATA_W:0], {FRAC_BITS{1'b0}}};
      end else begin
         unit_a = src_mag;
         unit_b = LO_W_FIX'(narrow_mag);
      end
   end

   // rounding, saturation and the integral and output arithmetic
   always_comb begin
      prod  = {unit_hi, unit_lo[LO_W_FIX-1 -: NARROW_W]};
      use16 = (op_ff == OP_INT) && reduce_ff;
      if (use16) begin
         quo = prod >> RESET_FRAC_SHIFT;
         rem = |prod[RESET_FRAC_SHIFT-1:0];
      end else begin
         quo = prod >> FRAC_BITS;
         rem = |prod[FRAC_BITS-1:0];
      end
      ovf   = |quo[PROD_W-1:TERM_W-1];
      mag_t = {1'b0, quo[TERM_W-2:0]};
      if (ovf) begin
         term_post = neg_ff ? TERM_MIN : TERM_MAX;
      end else if (neg_ff) begin
         term_post = -(mag_t + TERM_W'(rem));
      end else begin
         term_post = mag_t;
      end

      q_ext = {1'b0, unit_lo};
      if (dt_ff == '0) begin
         deriv_post = '0;
      end else begin
         deriv_post = neg_ff ? -q_ext : q_ext;
      end

      ext_int  = EXT_W'(integral_ff);
      ext_term = EXT_W'(term_ff);
      isum     = reduce_ff ? ext_int - ext_term : ext_int + ext_term;
      if ((&isum[EXT_W-1:INTEGRAL_WIDTH-1]) || !(|isum[EXT_W-1:INTEGRAL_WIDTH-1])) begin
         int_sat = isum[INTEGRAL_WIDTH-1:0];
      end else begin
         int_sat = isum[EXT_W-1] ? INT_MIN : INT_MAX;
      end

      upper_ext = VAL_W'(upper_ff);
      lower_ext = VAL_W'(lower_ff);
      clamp_hi  = (acc_ff < upper_ext) ? acc_ff : upper_ext;
      clamp_lo  = (clamp_hi > lower_ext) ? clamp_hi : lower_ext;

      xdiff = acc_ff - VAL_W'(clamped_ff);
      x_ok  = (&xdiff[VAL_W-1:EXCESS_W-1]) || !(|xdiff[VAL_W-1:EXCESS_W-1]);
      if (x_ok) begin
         excess_sat = xdiff[EXCESS_W-1:0];
      end else begin
         excess_sat = xdiff[VAL_W-1] ? EXC_MIN : EXC_MAX;
      end
   end

   // sequencer
   always_comb begin
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      sre_in       = sre_ff;
      frac_in      = frac_ff;
      state_in     = state_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      integral_in  = integral_ff;
      sign_in      = sign_ff;
      excess_in    = excess_ff;
      rsp_valid_in = rsp_valid_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      deriv_in     = deriv_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      clamped_in   = clamped_ff;
      limited_in   = limited_ff;
      reduce_in    = reduce_ff;
      neg_in       = neg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:     gain_p_in = csr_data;
            CSR_GAIN_I:     gain_i_in = csr_data;
            CSR_GAIN_D:     gain_d_in = csr_data;
            CSR_OUT_LOWER:  lower_in  = csr_data;
            CSR_OUT_UPPER:  upper_in  = csr_data;
            CSR_SIGN_RESET: sre_in    = csr_data[0];
            CSR_RESET_FRAC: frac_in   = csr_data[FRAC_W-1:0];
            default:        ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  clamped_in  = req_tdata[94:63];
                  limited_in  = 1'b0;
                  last_in     = '0;
                  integral_in = '0;
                  excess_in   = '0;
                  state_in    = S_FINISH;
               end else begin
                  err_in    = req_tdata[31:0];
                  dt_in     = req_tdata[62:32];
                  reduce_in = sre_ff && (req_tdata[31] != sign_ff);
                  acc_in    = '0;
                  op_in     = OP_INT;
                  state_in  = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            neg_in   = src[SRC_W-1] ^ gain_sel[DATA_W-1];
            state_in = S_RUN;
         end
         S_RUN: begin
            if (unit_status.done) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (op_ff == OP_DIV) begin
               deriv_in = deriv_post;
               last_in  = err_ff;
               op_in    = OP_P;
               state_in = S_LOAD;
            end else begin
               term_in  = term_post;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            case (op_ff)
               OP_INT: begin
                  integral_in = int_sat;
                  if (reduce_ff) begin
                     sign_in = ~sign_ff;
                  end
                  op_in    = OP_DIV;
                  state_in = S_LOAD;
               end
               OP_P: begin
                  acc_in   = acc_ff + VAL_W'(term_ff);
                  op_in    = OP_I;
                  state_in = S_LOAD;
               end
               OP_I: begin
                  acc_in   = acc_ff + VAL_W'(term_ff);
                  op_in    = OP_D;
                  state_in = S_LOAD;
               end
               OP_D: begin
                  acc_in   = acc_ff + VAL_W'(term_ff);
                  state_in = S_CLAMP;
               end
               default: state_in = S_CLAMP;
            endcase
         end
         S_CLAMP: begin
            clamped_in = clamp_lo[DATA_W-1:0];
            state_in   = S_EXCESS;
         end
         S_EXCESS: begin
            excess_in  = excess_sat;
            limited_in = |xdiff;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = clamped_ff;
               rsp_user_in  = limited_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         lower_ff     <= LOWER_RESET;
         upper_ff     <= UPPER_RESET;
         sre_ff       <= 1'b0;
         frac_ff      <= '0;
         last_ff      <= '0;
         integral_ff  <= '0;
         sign_ff      <= 1'b0;
         excess_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         sre_ff       <= sre_in;
         frac_ff      <= frac_in;
         last_ff      <= last_in;
         integral_ff  <= integral_in;
         sign_ff      <= sign_in;
         excess_ff    <= excess_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      err_ff      <= err_in;
      dt_ff       <= dt_in;
      deriv_ff    <= deriv_in;
      term_ff     <= term_in;
      acc_ff      <= acc_in;
      clamped_ff  <= clamped_in;
      limited_ff  <= limited_in;
      reduce_ff   <= reduce_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

   `PIDC_ASSERT(a_start_free, clock, reset, unit_ctrl.start |-> !unit_status.busy)
   `PIDC_ASSERT(a_accept_quiet, clock, reset, (req_tvalid && req_tready) |-> !unit_status.busy)
   `PIDC_ASSERT_MSG(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH), "result word loaded outside finish")
   `PIDC_ASSERT_MSG(a_sign_flip, clock, reset, (!$past(reset) && (sign_ff != $past(sign_ff))) |-> $past(state_ff == S_APPLY && op_ff == OP_INT && reduce_ff), "stored sign changed without reduction")

endmodule

// ----- rtl/core/pidc_iter_unit.sv -----
// shared shift-add multiplier and restoring divider, one bit a cycle
module pidc_iter_unit
   import pidc_pkg::*;
#(
   parameter int MAG_W = 49,
   parameter int LO_W  = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  unit_ctrl_type    ctrl,
   input  logic [MAG_W-1:0] op_a,
   input  logic [LO_W-1:0]  op_b,
   output unit_status_type  status,
   output logic [MAG_W-1:0] hi,
   output logic [LO_W-1:0]  lo
);

   localparam int CNT_W = $clog2(LO_W + 1);

   logic [MAG_W-1:0] hi_ff, hi_in;
   logic [LO_W-1:0]  lo_ff, lo_in;
   logic [MAG_W-1:0] a_ff, a_in;
   logic             div_ff, div_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [MAG_W-1:0] shifted;
   logic [MAG_W-1:0] x_op;
   logic [MAG_W:0]   y_op;
   logic [MAG_W:0]   sum;
   logic             borrow;

   always_comb begin
      shifted = {hi_ff[MAG_W-2:0], lo_ff[LO_W-1]};
      x_op    = div_ff ? shifted : hi_ff;
      y_op    = div_ff ? ~{1'b0, a_ff} : {1'b0, (lo_ff[0] ? a_ff : '0)};
      sum     = {1'b0, x_op} + y_op + (MAG_W+1)'(div_ff);
      borrow  = sum[MAG_W];

      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      div_in  = div_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;

      if (ctrl.start) begin
         hi_in   = '0;
         lo_in   = op_b;
         a_in    = op_a;
         div_in  = ctrl.is_div;
         busy_in = 1'b1;
         cnt_in  = ctrl.is_div ? CNT_W'(LO_W) : CNT_W'(NARROW_W);
      end else if (busy_ff) begin
         if (div_ff) begin
            hi_in = borrow ? shifted : sum[MAG_W-1:0];
            lo_in = {lo_ff[LO_W-2:0], ~borrow};
         end else begin
            hi_in = sum[MAG_W:1];
            lo_in = {sum[0], lo_ff[LO_W-1:1]};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign hi          = hi_ff;
   assign lo          = lo_ff;

endmodule

// ----- sim/pid_controller_antiwindup_checker.sv -----
module pid_controller_antiwindup_checker
   import pidc_pkg::*;
#(
   parameter int FRAC_BITS      = 16,
   parameter int INTEGRAL_WIDTH = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [DATA_W-1:0]     rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]     csr_data,
   output int                    fail_count,
   output int                    backlog
);

   typedef struct packed {
      logic [DATA_W-1:0] control_out;
      logic              limited;
   } loop_output_type;

   localparam longint TERM_HI  = (64'sd1 <<< (TERM_W - 1)) - 1;
   localparam longint TERM_LO  = -TERM_HI - 1;
   localparam longint EXC_HI   = (64'sd1 <<< (EXCESS_W - 1)) - 1;
   localparam longint EXC_LO   = -EXC_HI - 1;
   localparam longint INTEG_HI = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 1;
   localparam longint INTEG_LO = -INTEG_HI - 1;

   // register mirror
   longint kp, ki, kd, lim_lo, lim_hi, cut_frac;
   logic   cut_en;

   // loop state
   longint last_err, integ, excess;
   logic   neg_sign;

   loop_output_type expected_q[$];

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // exact product, floored shift, saturated to the term range
   function automatic longint scaled_product(input longint a, input longint b, input int sh);
      logic signed [127:0] wa, wb, q;
      wa = a;
      wb = b;
      q = (wa * wb) >>> sh;
      if (q > TERM_HI) return TERM_HI;
      if (q < TERM_LO) return TERM_LO;
      return longint'(q);
   endfunction

   function automatic loop_output_type regulate(input logic preset_word,
                                                input logic [REQ_DATA_W-1:0] w);
      longint err, dt, deriv, value, clamped;
      loop_output_type r;
      if (preset_word) begin
         last_err = 0;
         integ = 0;
         excess = 0;
         r.control_out = w[2*DATA_W+STEP_W-1:DATA_W+STEP_W];
         r.limited = 1'b0;
         return r;
      end
      err = $signed(w[DATA_W-1:0]);
      dt = w[DATA_W+STEP_W-1:DATA_W];
      deriv = 0;
      if (cut_en && ((err < 0) != neg_sign)) begin
         integ = clip(integ - scaled_product(integ, cut_frac, RESET_FRAC_SHIFT),
                      INTEG_LO, INTEG_HI);
         neg_sign = !neg_sign;
      end else begin
         integ = clip(integ + scaled_product(err - excess, dt, FRAC_BITS), INTEG_LO, INTEG_HI);
      end
      if (dt != 0) deriv = ((err - last_err) * (64'sd1 <<< FRAC_BITS)) / dt;
      last_err = err;
      value = scaled_product(kp, err, FRAC_BITS) + scaled_product(ki, integ, FRAC_BITS)
            + scaled_product(kd, deriv, FRAC_BITS);
      clamped = (value < lim_hi) ? value : lim_hi;
      if (clamped < lim_lo) clamped = lim_lo;
      excess = clip(value - clamped, EXC_LO, EXC_HI);
      r.control_out = clamped[DATA_W-1:0];
      r.limited = (value != clamped);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      loop_output_type want;
      if (reset) begin
         kp = 0;
         ki = 0;
         kd = 0;
         lim_lo = $signed(LOWER_RESET);
         lim_hi = $signed(UPPER_RESET);
         cut_en = 1'b0;
         cut_frac = 0;
         last_err = 0;
         integ = 0;
         excess = 0;
         neg_sign = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_GAIN_P:     kp = $signed(csr_data);
               CSR_GAIN_I:     ki = $signed(csr_data);
               CSR_GAIN_D:     kd = $signed(csr_data);
               CSR_OUT_LOWER:  lim_lo = $signed(csr_data);
               CSR_OUT_UPPER:  lim_hi = $signed(csr_data);
               CSR_SIGN_RESET: cut_en = csr_data[0];
               CSR_RESET_FRAC: cut_frac = csr_data[FRAC_W-1:0];
               default: ;
            endcase
         end
         // tuser high marks a preset word
         if (req_tvalid && req_tready) expected_q.push_back(regulate(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, got control_out %h limited %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata !== want.control_out) begin
                  fail_count++;
                  $display("%0t: control_out expected %h got %h",
                           $time, want.control_out, rsp_tdata);
               end
               if (rsp_tuser !== want.limited) begin
                  fail_count++;
                  $display("%0t: limited expected %b got %b", $time, want.limited, rsp_tuser);
               end
            end
         end
      end
      backlog = expected_q.size();
   end

endmodule

// ----- sim/pid_controller_antiwindup_core_test.sv -----
module pid_controller_antiwindup_core_test;
   import pidc_pkg::*;

   localparam int FRAC_BITS      = 16;
   localparam int INTEGRAL_WIDTH = 48;
   localparam int STALL_LIMIT    = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 72;

   typedef enum logic {
      REQ_UPDATE = 1'b0,
      REQ_PRESET = 1'b1
   } req_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // error_in, time_step, preset_value from bit 0 up
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // req_type
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // control_out
   logic [DATA_W-1:0]     rsp_tdata;
   // limited
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0]     csr_data = '0;

   int   fail_count;
   int   backlog;
   int   quiet_cycles = 0;
   logic tx_steady = 1'b0;
   logic rx_steady = 1'b0;

   pid_controller_antiwindup_core #(
      .FRAC_BITS      (FRAC_BITS),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pid_controller_antiwindup_checker #(
      .FRAC_BITS      (FRAC_BITS),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: always ready when steady, else wait for a word, stall, take it
   initial begin : rsp_side
      int stall;
      forever begin
         @(negedge clock);
         if (rx_steady) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            stall = $urandom_range(0, 8);
            repeat (stall) @(negedge clock);
            @(negedge clock);
            rsp_tready = 1'b1;
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send_word(input req_kind_type kind, input logic [DATA_W-1:0] err,
                            input logic [STEP_W-1:0] step, input logic [DATA_W-1:0] preset);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {1'b0, preset, step, err};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (backlog != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_loop_config(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                                  input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] lo,
                                  input logic [DATA_W-1:0] hi, input logic en,
                                  input logic [FRAC_W-1:0] frac);
      write_reg(CSR_GAIN_P, kp);
      write_reg(CSR_GAIN_I, ki);
      write_reg(CSR_GAIN_D, kd);
      write_reg(CSR_OUT_LOWER, lo);
      write_reg(CSR_OUT_UPPER, hi);
      write_reg(CSR_SIGN_RESET, {{(DATA_W-1){1'b0}}, en});
      write_reg(CSR_RESET_FRAC, {{(DATA_W-FRAC_W){1'b0}}, frac});
   endtask

   function automatic logic [DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return UPPER_RESET;
         2: return LOWER_RESET;
         3: return $urandom();
         default: return $urandom_range(0, 32'h40000) - 32'h20000;
      endcase
   endfunction

   // mostly a slow drift around the last error, so sign changes come naturally
   function automatic logic [DATA_W-1:0] pick_error(input logic [DATA_W-1:0] prior);
      case ($urandom_range(0, 15))
         0: return $urandom();
         1: return ($urandom_range(0, 1) != 0) ? UPPER_RESET : LOWER_RESET;
         2: return '0;
         3, 4: return $urandom_range(0, 32'h80000) - 32'h40000;
         default: return prior + $urandom_range(0, 32'h20000) - 32'h10000;
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return {STEP_W{1'b1}};
         2: return STEP_W'($urandom());
         3: return STEP_W'(1);
         default: return STEP_W'($urandom_range(32'h400, 32'h30000));
      endcase
   endfunction

   initial begin : stimulus
      logic [DATA_W-1:0] loop_err;
      logic [DATA_W-1:0] lo, hi;
      loop_err = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // register reset values
      send_word(REQ_UPDATE, 32'h0003_0000, 31'h1_0000, $urandom());
      send_word(REQ_PRESET, $urandom(), STEP_W'($urandom()), 32'h0001_8000);
      drain();

      set_loop_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'hFF9C_0000,
                      32'h0064_0000, 1'b1, 17'h08000);
      send_word(REQ_UPDATE, 32'h0000_0000, 31'h1_0000, $urandom());
      send_word(REQ_UPDATE, 32'h0005_0000, 31'h1_0000, $urandom());
      send_word(REQ_UPDATE, 32'hFFFD_0000, 31'h1_0000, $urandom());
      send_word(REQ_UPDATE, 32'hFFFD_0000, 31'h0_8000, $urandom());
      send_word(REQ_UPDATE, 32'h0000_0000, 31'h1_0000, $urandom());
      send_word(REQ_UPDATE, UPPER_RESET, 31'h1, $urandom());
      send_word(REQ_UPDATE, LOWER_RESET, 31'h1, $urandom());
      send_word(REQ_UPDATE, LOWER_RESET, 31'h0, $urandom());
      send_word(REQ_UPDATE, UPPER_RESET, {STEP_W{1'b1}}, $urandom());
      send_word(REQ_PRESET, $urandom(), STEP_W'($urandom()), UPPER_RESET);
      send_word(REQ_UPDATE, 32'h0001_0000, 31'h1_0000, $urandom());
      send_word(REQ_PRESET, $urandom(), STEP_W'($urandom()), LOWER_RESET);
      send_word(REQ_PRESET, $urandom(), STEP_W'($urandom()), 32'h0000_0000);
      drain();

      // crossed limits, fraction above one, extreme gains
      set_loop_config(UPPER_RESET, UPPER_RESET, LOWER_RESET, 32'h000A_0000, 32'hFFF6_0000,
                      1'b1, 17'h1FFFF);
      send_word(REQ_UPDATE, UPPER_RESET, {STEP_W{1'b1}}, $urandom());
      send_word(REQ_UPDATE, UPPER_RESET, {STEP_W{1'b1}}, $urandom());
      send_word(REQ_UPDATE, LOWER_RESET, {STEP_W{1'b1}}, $urandom());
      send_word(REQ_UPDATE, LOWER_RESET, {STEP_W{1'b1}}, $urandom());
      send_word(REQ_UPDATE, 32'h0000_0000, 31'h0, $urandom());
      drain();

      set_loop_config(LOWER_RESET, LOWER_RESET, UPPER_RESET, LOWER_RESET, UPPER_RESET,
                      1'b0, 17'h10000);
      send_word(REQ_UPDATE, LOWER_RESET, {STEP_W{1'b1}}, $urandom());
      send_word(REQ_UPDATE, LOWER_RESET, {STEP_W{1'b1}}, $urandom());
      send_word(REQ_UPDATE, UPPER_RESET, 31'h1, $urandom());
      send_word(REQ_PRESET, $urandom(), STEP_W'($urandom()), $urandom());

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case ($urandom_range(0, 5))
            0: begin
               lo = LOWER_RESET;
               hi = UPPER_RESET;
            end
            1: begin
               lo = $urandom_range(1, 32'h50000);
               hi = 0 - $urandom_range(0, 32'h50000);
            end
            default: begin
               lo = 0 - $urandom_range(0, 32'h200000);
               hi = $urandom_range(0, 32'h200000);
            end
         endcase
         set_loop_config(pick_gain(), pick_gain(), pick_gain(), lo, hi,
                         1'($urandom_range(0, 1)),
                         ($urandom_range(0, 3) == 0) ? 17'h1FFFF
                                                     : FRAC_W'($urandom_range(0, 32'h10000)));
         tx_steady = (phase % 3 == 2);
         rx_steady = (phase % 4 == 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 39) == 0) drain();
            if ($urandom_range(0, 14) == 0) begin
               send_word(REQ_PRESET, $urandom(), STEP_W'($urandom()), $urandom());
               loop_err = '0;
            end else begin
               loop_err = pick_error(loop_err);
               send_word(REQ_UPDATE, loop_err, pick_step(), $urandom());
            end
         end
      end

      drain();
      repeat (300) @(negedge clock);
      if (fail_count == 0 && backlog == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
